### src/tsis_pkg.sv
package tsis_pkg;

	localparam int RULE_ENTRIES = 64;
	localparam int TIME_SLOTS   = 24;
	localparam int MAX_STEPS    = 8;
	localparam int NUM_COLORS   = 3;
	localparam int DUR_ENTRIES  = TIME_SLOTS * NUM_COLORS;

	localparam int RULE_AW = $clog2(RULE_ENTRIES);
	localparam int DUR_AW  = (DUR_ENTRIES > 1) ? $clog2(DUR_ENTRIES) : 1;
	localparam int STEP_W  = $clog2(MAX_STEPS);
	localparam int SLOT_W  = 5;
	localparam int DUR_W   = 10;
	localparam int IVL_W   = 8;

	localparam logic [IVL_W-1:0] STEP_INTERVAL_RESET = IVL_W'(5);

	localparam logic [1:0] OP_WR_RULE = 2'd0;
	localparam logic [1:0] OP_WR_DUR  = 2'd1;
	localparam logic [1:0] OP_REGULATE = 2'd2;

	localparam logic [1:0] C_FLASH  = 2'd0;
	localparam logic [1:0] C_GREEN  = 2'd1;
	localparam logic [1:0] C_YELLOW = 2'd2;
	localparam logic [1:0] C_RED    = 2'd3;

	localparam logic [1:0] SC_FLASH   = 2'd0;
	localparam logic [1:0] SC_MAIN    = 2'd1;
	localparam logic [1:0] SC_SIDE    = 2'd2;
	localparam logic [1:0] SC_ALL_RED = 2'd3;

	localparam logic [1:0] ORD_NONE    = 2'd0;
	localparam logic [1:0] ORD_MAIN    = 2'd1;
	localparam logic [1:0] ORD_SIDE    = 2'd2;
	localparam logic [1:0] ORD_ALL_RED = 2'd3;

	localparam logic [1:0] SEL_GREEN  = 2'd0;
	localparam logic [1:0] SEL_YELLOW = 2'd1;
	localparam logic [1:0] SEL_RED    = 2'd2;

	typedef struct packed {
		logic [1:0]        op;
		logic [1:0]        flow_primary;
		logic [1:0]        flow_secondary;
		logic [1:0]        state_code;
		logic [1:0]        rule_order;
		logic [SLOT_W-1:0] time_slot;
		logic [1:0]        color_select;
		logic [DUR_W-1:0]  duration_value;
	} in_word_t;

	typedef struct packed {
		logic [1:0]       head_primary;
		logic [1:0]       head_secondary;
		logic [DUR_W-1:0] phase_time;
		logic             last;
		logic [1:0]       order_taken;
		logic             not_reached;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RULE,
		ST_STEP,
		ST_DUR
	} state_t;

	function automatic logic [1:0] state_code_of(input logic [1:0] a, input logic [1:0] b);
		logic [1:0] sc;
		sc = SC_FLASH;
		if (a == C_GREEN && b == C_RED) sc = SC_MAIN;
		if (a == C_RED && b == C_GREEN) sc = SC_SIDE;
		if (a == C_RED && b == C_RED)   sc = SC_ALL_RED;
		return sc;
	endfunction

	function automatic logic [1:0] color_sel_of(input logic [1:0] head);
		logic [1:0] c;
		case (head)
			C_GREEN:  c = SEL_GREEN;
			C_YELLOW: c = SEL_YELLOW;
			default:  c = SEL_RED;
		endcase
		return c;
	endfunction

	function automatic logic slot_ok(input logic [SLOT_W-1:0] slot);
		return {1'b0, slot} < (SLOT_W+1)'(TIME_SLOTS);
	endfunction

	function automatic logic [DUR_AW-1:0] dur_addr(input logic [SLOT_W-1:0] slot,
		input logic [1:0] c);
		return DUR_AW'(int'(slot) * NUM_COLORS + int'(c));
	endfunction

endpackage

### src/tsis_ram.sv
module tsis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/two_signal_intersection_sequencer_core.sv
// Two-head intersection sequencer. Rule writes and duration writes leave the
// input open. A regulate word reads the rule memory, then steps the pair of
// heads once per cycle while out_stall does not hold the output register, with
// one result word per step, and finally reads the duration memory for the last
// result. The single output register paces the steps. Rule and duration
// entries that were never written read as zero through per-entry valid flops
// cleared by reset, so no clearing pass is needed. cfg_data sets the time
// given on intermediate steps and may be written whenever the block is idle.
module two_signal_intersection_sequencer_core import tsis_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IVL_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_word_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_word_t        out_data
);

	state_t state_q, state_d;

	logic [IVL_W-1:0]  step_ivl_q;
	logic [1:0]        head_p_q, head_s_q, head_pb_q, head_sb_q;
	logic [STEP_W-1:0] n_q;
	logic [1:0]        order_q, tgt_p_q, tgt_s_q;
	logic [SLOT_W-1:0] slot_q;
	logic              reached_q;
	logic              rule_hit_s1, dur_hit_s1;
	logic              out_valid_q;
	out_word_t         out_q;

	logic [RULE_ENTRIES-1:0] rule_vld_q;
	logic [DUR_ENTRIES-1:0]  dur_vld_q;

	logic              accept, out_free;
	logic              rule_we, rule_re, dur_we, dur_re;
	logic [RULE_AW-1:0] rule_waddr, rule_raddr;
	logic [DUR_AW-1:0]  dur_waddr, dur_raddr;
	logic [1:0]        rule_rdata;
	logic [DUR_W-1:0]  dur_rdata;

	logic [1:0]        order_rd, na, nb;
	logic              reached, fin;
	logic              do_step, load_rule, load_mid, load_last;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign rule_waddr = {in_data.flow_primary, in_data.flow_secondary, in_data.state_code};
	assign rule_raddr = {in_data.flow_primary, in_data.flow_secondary,
		state_code_of(head_p_q, head_s_q)};
	assign rule_we = accept && in_data.op == OP_WR_RULE;
	assign rule_re = accept && in_data.op == OP_REGULATE;

	assign dur_waddr = dur_addr(in_data.time_slot, in_data.color_select);
	assign dur_we = accept && in_data.op == OP_WR_DUR && slot_ok(in_data.time_slot)
		&& in_data.color_select != 2'd3;

	assign order_rd = rule_hit_s1 ? rule_rdata : ORD_NONE;

	// successor colors from the current and previous heads
	always_comb begin
		if (head_p_q == C_FLASH && head_s_q == C_FLASH) begin
			na = C_RED;
			nb = C_RED;
		end else begin
			if (head_p_q == C_RED) begin
				na = (head_pb_q == C_YELLOW || head_s_q == C_GREEN || head_s_q == C_YELLOW)
					? C_RED : C_GREEN;
			end else begin
				na = head_p_q + 2'd1;
			end
			if (head_s_q == C_RED) begin
				nb = (head_sb_q == C_YELLOW || head_p_q == C_GREEN || head_p_q == C_YELLOW
					|| head_pb_q == C_FLASH) ? C_RED : C_GREEN;
			end else begin
				nb = head_s_q + 2'd1;
			end
		end
	end

	assign reached = (order_q == ORD_NONE) || (na == tgt_p_q && nb == tgt_s_q);
	assign fin     = reached || (n_q == STEP_W'(MAX_STEPS - 1));
	assign dur_raddr = dur_addr(slot_q, color_sel_of(na));

	always_comb begin
		state_d   = state_q;
		load_rule = 1'b0;
		do_step   = 1'b0;
		load_mid  = 1'b0;
		load_last = 1'b0;
		dur_re    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (rule_re) state_d = ST_RULE;
			end
			ST_RULE: begin
				load_rule = 1'b1;
				state_d   = ST_STEP;
			end
			ST_STEP: begin
				if (out_free) begin
					do_step = 1'b1;
					if (fin) begin
						dur_re  = 1'b1;
						state_d = ST_DUR;
					end else begin
						load_mid = 1'b1;
					end
				end
			end
			ST_DUR: begin
				if (out_free) begin
					load_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_ivl_q  <= STEP_INTERVAL_RESET;
			head_p_q    <= C_FLASH;
			head_s_q    <= C_FLASH;
			head_pb_q   <= C_FLASH;
			head_sb_q   <= C_FLASH;
			n_q         <= '0;
			out_valid_q <= 1'b0;
			rule_vld_q  <= '0;
			dur_vld_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) step_ivl_q <= cfg_data;
			if (rule_we) rule_vld_q[rule_waddr] <= 1'b1;
			if (dur_we) dur_vld_q[dur_waddr] <= 1'b1;
			if (load_rule) n_q <= '0;
			if (do_step) begin
				head_pb_q <= head_p_q;
				head_sb_q <= head_s_q;
				head_p_q  <= na;
				head_s_q  <= nb;
				if (!fin) n_q <= n_q + STEP_W'(1);
			end
			if (load_mid || load_last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rule_re) begin
			rule_hit_s1 <= rule_vld_q[rule_raddr];
			slot_q      <= in_data.time_slot;
		end
		if (load_rule) begin
			order_q <= order_rd;
			case (order_rd)
				ORD_MAIN: begin
					tgt_p_q <= C_GREEN;
					tgt_s_q <= C_RED;
				end
				ORD_SIDE: begin
					tgt_p_q <= C_RED;
					tgt_s_q <= C_GREEN;
				end
				ORD_ALL_RED: begin
					tgt_p_q <= C_RED;
					tgt_s_q <= C_RED;
				end
				default: begin
					tgt_p_q <= C_FLASH;
					tgt_s_q <= C_FLASH;
				end
			endcase
		end
		if (dur_re) begin
			dur_hit_s1 <= slot_ok(slot_q) && dur_vld_q[dur_raddr];
			reached_q  <= reached;
		end
		if (load_mid) begin
			out_q.head_primary   <= na;
			out_q.head_secondary <= nb;
			out_q.phase_time     <= DUR_W'(step_ivl_q);
			out_q.last           <= 1'b0;
			out_q.order_taken    <= order_q;
			out_q.not_reached    <= 1'b0;
		end else if (load_last) begin
			out_q.head_primary   <= head_p_q;
			out_q.head_secondary <= head_s_q;
			out_q.phase_time     <= dur_hit_s1 ? dur_rdata : '0;
			out_q.last           <= 1'b1;
			out_q.order_taken    <= order_q;
			out_q.not_reached    <= !reached_q;
		end
	end

	tsis_ram #(.WIDTH(2), .DEPTH(RULE_ENTRIES), .AW(RULE_AW)) u_rule_ram (
		.clk   (clk),
		.we    (rule_we),
		.waddr (rule_waddr),
		.wdata (in_data.rule_order),
		.re    (rule_re),
		.raddr (rule_raddr),
		.rdata (rule_rdata)
	);

	tsis_ram #(.WIDTH(DUR_W), .DEPTH(DUR_ENTRIES), .AW(DUR_AW)) u_dur_ram (
		.clk   (clk),
		.we    (dur_we),
		.waddr (dur_waddr),
		.wdata (in_data.duration_value),
		.re    (dur_re),
		.raddr (dur_raddr),
		.rdata (dur_rdata)
	);

endmodule

### src/tsis_checker.sv
module tsis_checker import tsis_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input in_word_t         in_data,
	input logic             out_valid,
	input logic             out_stall,
	input out_word_t        out_data
);

	// a stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output word changed");

	// a regulate word keeps the input closed while its steps run
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.op == OP_REGULATE |=> in_stall)
		else $error("input open right after regulate");

	// table writes leave the input open
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (in_data.op == OP_WR_RULE || in_data.op == OP_WR_DUR)
		|=> !in_stall)
		else $error("input stalled after a write");

	// the input stays closed after a result word that is not last
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.last |=> in_stall)
		else $error("sequence ended without a last word");

	// not_reached only on the last word
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.not_reached |-> out_data.last)
		else $error("not_reached on an intermediate word");

endmodule

bind two_signal_intersection_sequencer_core tsis_checker u_tsis_checker (.*);
